// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB overlap package
// Shared constants and types for the box overlap pipeline.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Per-transaction control flags handed down the cell chain.
    typedef struct packed {
        logic valid;
        logic hit;
        logic use_vel;
        logic neg_x;
        logic neg_y;
    } t_ctrl;

endpackage

// ===== rtl/aabb_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB root cell
// One restoring square root step: retires one result bit per enabled cycle
// and hands its remainder, root and the transaction payload to the next cell.
// ----------------------------------------------------------------------------
module aabb_sqrt_cell
    import aabb_pkg::*;
#(
    parameter int NW = 34,   // radicand width
    parameter int RW = 17,   // root width
    parameter int PW = 8,    // side payload width
    parameter int STEP = 0   // bit pair handled here, counted from the top
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctrl         i_ctrl,
    input  logic [NW-1:0] i_rad,
    input  logic [RW:0]   i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [PW-1:0] i_pay,
    output t_ctrl         o_ctrl,
    output logic [NW-1:0] o_rad,
    output logic [RW:0]   o_rem,
    output logic [RW-1:0] o_root,
    output logic [PW-1:0] o_pay
);

    localparam int LO = NW - 2 * STEP - 2;

    logic [RW+2:0] trial_rem;
    logic [RW+2:0] trial_sub;
    logic [RW:0]   n_rem;
    logic [RW-1:0] n_root;

    always_comb begin
        trial_rem = {i_rem, i_rad[LO+1 -: 2]};
        trial_sub = {1'b0, i_root, 2'b01};
        if (trial_rem >= trial_sub) begin
            n_rem  = (RW+1)'(trial_rem - trial_sub);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = trial_rem[RW:0];
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    t_ctrl         r_ctrl;
    logic [NW-1:0] r_rad;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [PW-1:0] r_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= i_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_pay  <= i_pay;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pay  = r_pay;

endmodule

// ===== rtl/aabb_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB divide cell
// One restoring division step for both axes at once: shifts in one dividend
// bit per axis and retires one quotient bit per axis.
// ----------------------------------------------------------------------------
module aabb_div_cell
    import aabb_pkg::*;
#(
    parameter int DW = 33,   // dividend width
    parameter int RW = 17,   // divisor width
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctrl         i_ctrl,
    input  logic [RW-1:0] i_den,
    input  logic [DW-1:0] i_num_x,
    input  logic [DW-1:0] i_num_y,
    input  logic [RW-1:0] i_rem_x,
    input  logic [RW-1:0] i_rem_y,
    input  logic [DW-1:0] i_quo_x,
    input  logic [DW-1:0] i_quo_y,
    output t_ctrl         o_ctrl,
    output logic [RW-1:0] o_den,
    output logic [DW-1:0] o_num_x,
    output logic [DW-1:0] o_num_y,
    output logic [RW-1:0] o_rem_x,
    output logic [RW-1:0] o_rem_y,
    output logic [DW-1:0] o_quo_x,
    output logic [DW-1:0] o_quo_y
);

    localparam int BIT = DW - 1 - STEP;

    logic [RW:0]   tx, ty;
    logic [RW-1:0] n_rem_x, n_rem_y;
    logic [DW-1:0] n_quo_x, n_quo_y;

    always_comb begin
        tx = {i_rem_x, i_num_x[BIT]};
        ty = {i_rem_y, i_num_y[BIT]};
        n_quo_x = i_quo_x;
        n_quo_y = i_quo_y;
        if (tx >= {1'b0, i_den}) begin
            n_rem_x = RW'(tx - {1'b0, i_den});
            n_quo_x[BIT] = 1'b1;
        end else begin
            n_rem_x = tx[RW-1:0];
        end
        if (ty >= {1'b0, i_den}) begin
            n_rem_y = RW'(ty - {1'b0, i_den});
            n_quo_y[BIT] = 1'b1;
        end else begin
            n_rem_y = ty[RW-1:0];
        end
    end

    t_ctrl         r_ctrl;
    logic [RW-1:0] r_den, r_rem_x, r_rem_y;
    logic [DW-1:0] r_num_x, r_num_y, r_quo_x, r_quo_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_num_x <= i_num_x;
            r_num_y <= i_num_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= n_quo_x;
            r_quo_y <= n_quo_y;
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_den   = r_den;
    assign o_num_x = r_num_x;
    assign o_num_y = r_num_y;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

endmodule

// ===== rtl/aabb_overlap_separation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB overlap and separation
// Streams box pairs and returns a hit flag and a push-out separation vector.
// ----------------------------------------------------------------------------
// The block accepts one box-pair transaction per clock unless o_stall is high
// and returns one result transaction per input in order. One front stage
// computes the overlap test and penetrations, one stage squares the velocity,
// a chain of C+1 root cells takes the integer square root of the squared
// length one bit per cell, one stage forms the products, a chain of 2C+1
// divide cells divides both axes one quotient bit per cell, and a final
// output register applies the signs. A stall on the output freezes the whole
// chain, so the input stall follows the output stall while the last stage
// is full.
// ----------------------------------------------------------------------------
module aabb_overlap_separation
    import aabb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_a_min_x,
    input  logic signed [COORD_BITS-1:0] i_a_min_y,
    input  logic signed [COORD_BITS-1:0] i_a_max_x,
    input  logic signed [COORD_BITS-1:0] i_a_max_y,
    input  logic signed [COORD_BITS-1:0] i_b_min_x,
    input  logic signed [COORD_BITS-1:0] i_b_min_y,
    input  logic signed [COORD_BITS-1:0] i_b_max_x,
    input  logic signed [COORD_BITS-1:0] i_b_max_y,
    input  logic signed [COORD_BITS-1:0] i_vel_x,
    input  logic signed [COORD_BITS-1:0] i_vel_y,
    input  logic                         i_has_velocity,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic signed [COORD_BITS:0]   o_sep_x,
    output logic signed [COORD_BITS:0]   o_sep_y
);

    localparam int C  = COORD_BITS;
    localparam int PM = C + 1;          // penetration magnitude width
    localparam int NW = 2 * C + 2;      // squared length width, even
    localparam int RW = C + 1;          // root width
    localparam int SQ = NW / 2;         // number of root cells
    localparam int DW = PM + C;         // product width
    localparam int DS = DW;             // number of divide cells
    localparam int PW = 2 * PM + 2 * C; // payload through root chain

    // The whole chain advances when the output slot is free or empty.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- Front stage: overlap and penetration ----------------
    logic                hit_c;
    logic signed [C:0]   pen_x, pen_y;
    logic [C-1:0]        mag_vx, mag_vy;
    logic [PM-1:0]       mag_px, mag_py;
    logic                use_c;

    always_comb begin
        hit_c = !((i_a_min_x > i_b_max_x) || (i_a_max_x <= i_b_min_x) ||
                  (i_a_min_y > i_b_max_y) || (i_a_max_y <= i_b_min_y));
        if (i_b_min_x >= i_a_min_x && i_b_min_x <= i_a_max_x) begin
            pen_x = (C+1)'(i_b_min_x) - (C+1)'(i_a_max_x);
        end else begin
            pen_x = (C+1)'(i_b_max_x) - (C+1)'(i_a_min_x);
        end
        if (i_b_min_y >= i_a_min_y && i_b_min_y <= i_a_max_y) begin
            pen_y = (C+1)'(i_b_min_y) - (C+1)'(i_a_max_y);
        end else begin
            pen_y = (C+1)'(i_b_max_y) - (C+1)'(i_a_min_y);
        end
        mag_vx = i_vel_x[C-1] ? C'(-i_vel_x) : C'(i_vel_x);
        mag_vy = i_vel_y[C-1] ? C'(-i_vel_y) : C'(i_vel_y);
        mag_px = pen_x[C] ? PM'(-pen_x) : PM'(pen_x);
        mag_py = pen_y[C] ? PM'(-pen_y) : PM'(pen_y);
        use_c  = i_has_velocity && (i_vel_x != '0 || i_vel_y != '0);
    end

    t_ctrl         r_f_ctrl;
    logic [PM-1:0] r_f_px, r_f_py;
    logic [C-1:0]  r_f_vx, r_f_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctrl <= '0;
        end else if (en) begin
            r_f_ctrl.valid   <= i_valid;
            r_f_ctrl.hit     <= hit_c;
            r_f_ctrl.use_vel <= use_c;
            r_f_ctrl.neg_x   <= pen_x[C];
            r_f_ctrl.neg_y   <= pen_y[C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_px <= mag_px;
            r_f_py <= mag_py;
            r_f_vx <= mag_vx;
            r_f_vy <= mag_vy;
        end
    end

    // ---------------- Square stage ----------------
    t_ctrl         r_s_ctrl;
    logic [NW-1:0] r_s_len2;
    logic [PW-1:0] r_s_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ctrl <= '0;
        end else if (en) begin
            r_s_ctrl <= r_f_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_len2 <= NW'(r_f_vx * r_f_vx) + NW'(r_f_vy * r_f_vy);
            r_s_pay  <= {r_f_px, r_f_py, r_f_vx, r_f_vy};
        end
    end

    // ---------------- Root chain ----------------
    t_ctrl         q_ctrl [SQ+1];
    logic [NW-1:0] q_rad  [SQ+1];
    logic [RW:0]   q_rem  [SQ+1];
    logic [RW-1:0] q_root [SQ+1];
    logic [PW-1:0] q_pay  [SQ+1];

    assign q_ctrl[0] = r_s_ctrl;
    assign q_rad[0]  = r_s_len2;
    assign q_rem[0]  = '0;
    assign q_root[0] = '0;
    assign q_pay[0]  = r_s_pay;

    for (genvar g = 0; g < SQ; g++) begin : g_sqrt
        aabb_sqrt_cell #(.NW(NW), .RW(RW), .PW(PW), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctrl (q_ctrl[g]),
            .i_rad  (q_rad[g]),
            .i_rem  (q_rem[g]),
            .i_root (q_root[g]),
            .i_pay  (q_pay[g]),
            .o_ctrl (q_ctrl[g+1]),
            .o_rad  (q_rad[g+1]),
            .o_rem  (q_rem[g+1]),
            .o_root (q_root[g+1]),
            .o_pay  (q_pay[g+1])
        );
    end

    // ---------------- Product stage ----------------
    logic [PM-1:0] px, py;
    logic [C-1:0]  vx, vy;
    assign {px, py, vx, vy} = q_pay[SQ];

    t_ctrl         r_m_ctrl;
    logic [RW-1:0] r_m_den;
    logic [DW-1:0] r_m_nx, r_m_ny;
    logic [PM-1:0] r_m_px, r_m_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctrl <= '0;
        end else if (en) begin
            r_m_ctrl <= q_ctrl[SQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // A zero root only happens without velocity; keep divisor nonzero.
            r_m_den <= (q_root[SQ] == '0) ? RW'(1) : q_root[SQ];
            r_m_nx  <= DW'(px * vx);
            r_m_ny  <= DW'(py * vy);
            r_m_px  <= px;
            r_m_py  <= py;
        end
    end

    // ---------------- Divide chain ----------------
    // The raw penetrations ride alongside in a small shift line.
    t_ctrl         d_ctrl  [DS+1];
    logic [RW-1:0] d_den   [DS+1];
    logic [DW-1:0] d_nx    [DS+1];
    logic [DW-1:0] d_ny    [DS+1];
    logic [RW-1:0] d_rx    [DS+1];
    logic [RW-1:0] d_ry    [DS+1];
    logic [DW-1:0] d_qx    [DS+1];
    logic [DW-1:0] d_qy    [DS+1];
    logic [2*PM-1:0] r_side [DS];

    assign d_ctrl[0] = r_m_ctrl;
    assign d_den[0]  = r_m_den;
    assign d_nx[0]   = r_m_nx;
    assign d_ny[0]   = r_m_ny;
    assign d_rx[0]   = '0;
    assign d_ry[0]   = '0;
    assign d_qx[0]   = '0;
    assign d_qy[0]   = '0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= {r_m_px, r_m_py};
            for (int k = 1; k < DS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    for (genvar g = 0; g < DS; g++) begin : g_div
        aabb_div_cell #(.DW(DW), .RW(RW), .STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctrl (d_ctrl[g]),
            .i_den  (d_den[g]),
            .i_num_x(d_nx[g]),
            .i_num_y(d_ny[g]),
            .i_rem_x(d_rx[g]),
            .i_rem_y(d_ry[g]),
            .i_quo_x(d_qx[g]),
            .i_quo_y(d_qy[g]),
            .o_ctrl (d_ctrl[g+1]),
            .o_den  (d_den[g+1]),
            .o_num_x(d_nx[g+1]),
            .o_num_y(d_ny[g+1]),
            .o_rem_x(d_rx[g+1]),
            .o_rem_y(d_ry[g+1]),
            .o_quo_x(d_qx[g+1]),
            .o_quo_y(d_qy[g+1])
        );
    end

    // ---------------- Output stage ----------------
    t_ctrl          fc;
    logic [PM-1:0]  ex, ey, sel_x, sel_y;
    logic signed [C:0] n_sep_x, n_sep_y;

    always_comb begin
        fc = d_ctrl[DS];
        {ex, ey} = r_side[DS-1];
        if (fc.use_vel) begin
            // Quotient never exceeds the penetration magnitude.
            sel_x = d_qx[DS][PM-1:0];
            sel_y = d_qy[DS][PM-1:0];
        end else if (ex > ey) begin
            sel_x = '0;
            sel_y = ey;
        end else begin
            sel_x = ex;
            sel_y = '0;
        end
        n_sep_x = fc.neg_x ? -$signed(sel_x) : $signed(sel_x);
        n_sep_y = fc.neg_y ? -$signed(sel_y) : $signed(sel_y);
        if (!fc.hit) begin
            n_sep_x = '0;
            n_sep_y = '0;
        end
    end

    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit   <= fc.hit;
            o_sep_x <= n_sep_x;
            o_sep_y <= n_sep_y;
        end
    end

    assign o_valid = r_out_valid;

    // ---------------- Assertions ----------------
    a_no_sep_without_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_sep_x == '0 && o_sep_y == '0))
        else $error("separation without hit");

    a_one_axis_without_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && fc.valid && fc.hit && !fc.use_vel |=> (o_sep_x == '0 || o_sep_y == '0))
        else $error("both axes kept without velocity");

    a_stall_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_sep_x) && $stable(o_sep_y) && o_valid)
        else $error("stalled result changed");

endmodule

// ===== verif/aabb_overlap_separation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB overlap and separation testbench
// Streams box pairs through the block with random idling on both sides and
// checks every result against a behavioral predictor of the overlap test and
// the separation arithmetic.
// ----------------------------------------------------------------------------
module aabb_overlap_separation_test;
    import aabb_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int LATENCY = 4 + (CB + 1) + (2 * CB + 1);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PAIRS = 1330;

    // One box-pair query as the driver presents it.
    typedef struct packed {
        logic signed [CB-1:0] a_min_x, a_min_y, a_max_x, a_max_y;
        logic signed [CB-1:0] b_min_x, b_min_y, b_max_x, b_max_y;
        logic signed [CB-1:0] vel_x, vel_y;
        logic                 has_velocity;
    } t_query;

    // One result transaction.
    typedef struct packed {
        logic              hit;
        logic signed [CB:0] sep_x;
        logic signed [CB:0] sep_y;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_hit;
    logic signed [CB:0] o_sep_x, o_sep_y;
    t_query drive_q = '0;

    t_query   pending_queries[$];
    t_contact expected_contacts[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    bit       calm_phase = 1'b0;    // no idling during the last part of the run
    bit       hold_off_req = 1'b0;  // requests the long receiver hold-off

    always #2 i_clk = ~i_clk;

    aabb_overlap_separation uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_a_min_x(drive_q.a_min_x), .i_a_min_y(drive_q.a_min_y),
        .i_a_max_x(drive_q.a_max_x), .i_a_max_y(drive_q.a_max_y),
        .i_b_min_x(drive_q.b_min_x), .i_b_min_y(drive_q.b_min_y),
        .i_b_max_x(drive_q.b_max_x), .i_b_max_y(drive_q.b_max_y),
        .i_vel_x(drive_q.vel_x), .i_vel_y(drive_q.vel_y),
        .i_has_velocity(drive_q.has_velocity),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hit(o_hit), .o_sep_x(o_sep_x), .o_sep_y(o_sep_y)
    );

    // Floor square root by the classic bit-pair method.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root, probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Penetration along one axis: entering from B's low edge or its high edge.
    function automatic longint axis_depth(input longint amin, amax, bmin, bmax);
        if (bmin >= amin && bmin <= amax) return bmin - amax;
        return bmax - amin;
    endfunction

    // Scales a penetration by |v_axis| / length, truncating toward zero.
    function automatic longint scale_depth(input longint depth,
                                           input longint unsigned vmag, len);
        longint unsigned q;
        q = ((depth < 0 ? -depth : depth) * vmag) / len;
        return depth < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_contact predict_contact(input t_query q);
        t_contact c;
        longint sx, sy, vx, vy;
        longint unsigned mx, my, len;
        sx = 0;
        sy = 0;
        vx = q.vel_x;
        vy = q.vel_y;
        // Touching counts on B's high side only.
        c.hit = !(q.a_min_x > q.b_max_x || q.a_max_x <= q.b_min_x ||
                  q.a_min_y > q.b_max_y || q.a_max_y <= q.b_min_y);
        if (c.hit) begin
            sx = axis_depth(q.a_min_x, q.a_max_x, q.b_min_x, q.b_max_x);
            sy = axis_depth(q.a_min_y, q.a_max_y, q.b_min_y, q.b_max_y);
            // A zero-length velocity falls back to the smaller-axis rule.
            if (q.has_velocity && (vx != 0 || vy != 0)) begin
                mx = vx < 0 ? -vx : vx;
                my = vy < 0 ? -vy : vy;
                len = floor_root(mx * mx + my * my);
                sx = scale_depth(sx, mx, len);
                sy = scale_depth(sy, my, len);
            end else if ((sx < 0 ? -sx : sx) > (sy < 0 ? -sy : sy)) begin
                sx = 0;
            end else begin
                // On equal magnitudes y is the axis that is dropped.
                sy = 0;
            end
        end
        c.sep_x = sx[CB:0];
        c.sep_y = sy[CB:0];
        return c;
    endfunction

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return CB'($urandom());
        endcase
    endfunction

    // Overlapping pair with random extents, so most random traffic exercises
    // the separation arithmetic; a fraction is fully random noise.
    function automatic t_query random_query();
        t_query q;
        int cx, cy;
        q.vel_x = ($urandom_range(0, 9) == 0) ? 16'sd0 : rand_coord();
        q.vel_y = ($urandom_range(0, 9) == 0) ? 16'sd0 : rand_coord();
        q.has_velocity = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            q.a_min_x = rand_coord(); q.a_min_y = rand_coord();
            q.a_max_x = rand_coord(); q.a_max_y = rand_coord();
            q.b_min_x = rand_coord(); q.b_min_y = rand_coord();
            q.b_max_x = rand_coord(); q.b_max_y = rand_coord();
        end else begin
            cx = $urandom_range(0, 60000) - 30000;
            cy = $urandom_range(0, 60000) - 30000;
            q.a_min_x = CB'(cx - $urandom_range(0, 2000));
            q.a_max_x = CB'(cx + $urandom_range(1, 2000));
            q.a_min_y = CB'(cy - $urandom_range(0, 2000));
            q.a_max_y = CB'(cy + $urandom_range(1, 2000));
            q.b_min_x = CB'(cx - $urandom_range(0, 2000));
            q.b_max_x = CB'(cx + $urandom_range(0, 2000));
            q.b_min_y = CB'(cy - $urandom_range(0, 2000));
            q.b_max_y = CB'(cy + $urandom_range(0, 2000));
        end
        return q;
    endfunction

    function automatic t_query make_query(input int amnx, amny, amxx, amxy,
                                          bmnx, bmny, bmxx, bmxy, vx, vy,
                                          input bit usev);
        t_query q;
        q.a_min_x = CB'(amnx); q.a_min_y = CB'(amny);
        q.a_max_x = CB'(amxx); q.a_max_y = CB'(amxy);
        q.b_min_x = CB'(bmnx); q.b_min_y = CB'(bmny);
        q.b_max_x = CB'(bmxx); q.b_max_y = CB'(bmxy);
        q.vel_x = CB'(vx); q.vel_y = CB'(vy); q.has_velocity = usev;
        return q;
    endfunction

    // Driver: presents queued queries, idling in random bursts, and holds
    // the payload steady while the block stalls. The query on the bus stays
    // at the head of the queue until it is accepted.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) void'(pending_queries.pop_front());
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_queries.size() > 0) begin
                if (!calm_phase && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 14) - 1;
                    i_valid <= 1'b0;
                end else begin
                    drive_q <= pending_queries[0];
                    i_valid <= 1'b1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Expectations are formed at acceptance, in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            expected_contacts.push_back(predict_contact(drive_q));
    end

    // Receiver stall: random bursts, plus one long hold-off on request.
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off_req && hold_left == 0) begin
            hold_left <= 300;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= (hold_left > 1);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_contacts.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result hit=%0b sep=(%0d,%0d)",
                             o_hit, o_sep_x, o_sep_y);
            end else begin
                want = expected_contacts.pop_front();
                if (want.hit !== o_hit || want.sep_x !== o_sep_x ||
                    want.sep_y !== o_sep_y) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display({"mismatch: expected hit=%0b sep=(%0d,%0d) ",
                                  "got hit=%0b sep=(%0d,%0d)"},
                                 want.hit, want.sep_x, want.sep_y,
                                 o_hit, o_sep_x, o_sep_y);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL aabb_overlap_separation");
            $finish;
        end
    end

    initial begin
        // Directed: boundaries of the touch rule, malformed boxes, equal
        // magnitudes, zero-length velocity and the coordinate extremes.
        pending_queries.push_back(make_query(0, 0, 10, 10, 10, 0, 20, 10, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, -10, 0, 0, 10, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, 11, 0, 20, 10, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, 0, -10, 10, 0, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, 5, 5, 15, 15, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, 4, 7, 15, 15, 0, 0, 0));
        pending_queries.push_back(make_query(0, 0, 10, 10, 5, 5, 15, 15, 0, 0, 1));
        pending_queries.push_back(make_query(0, 0, 10, 10, 5, 5, 15, 15, 3, -4, 1));
        pending_queries.push_back(make_query(0, 0, 10, 10, -5, -3, 5, 5, -7, 0, 1));
        pending_queries.push_back(make_query(10, 10, 0, 0, 5, 5, 2, 2, 1, 1, 1));
        pending_queries.push_back(make_query(-32768, -32768, 32767, 32767,
                                             -32768, -32768, 32767, 32767, 0, 0, 0));
        pending_queries.push_back(make_query(-32768, -32768, 32767, 32767,
                                             -32767, -32767, 32767, 32767,
                                             -32768, -32768, 1));
        pending_queries.push_back(make_query(-32768, -32768, 32767, 32767,
                                             32767, 32767, -32768, -32768,
                                             32767, -32768, 1));
        pending_queries.push_back(make_query(-32768, -32768, -32768, -32768,
                                             -32768, -32768, 32767, 32767,
                                             32767, 32767, 1));
        pending_queries.push_back(make_query(0, 0, 5, 5, 2, 2, 3, 3, 1, 0, 1));
        pending_queries.push_back(make_query(0, 0, 5, 5, 2, 2, 3, 3, 0, -1, 1));
        pending_queries.push_back(make_query(0, 0, 5, 5, 2, 2, 3, 3, 0, 0, 1));
        pending_queries.push_back(make_query(-21846, 21845, -1, 1, -21846, 21845,
                                             21845, -21846, -21846, 21845, 1));
        repeat (RANDOM_PAIRS) pending_queries.push_back(random_query());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Long hold-off once the pipe has traffic, so the block backs up.
        wait (pending_queries.size() < RANDOM_PAIRS - 200);
        @(posedge i_clk);
        hold_off_req <= 1'b1;
        @(posedge i_clk);
        hold_off_req <= 1'b0;

        wait (pending_queries.size() < 200);
        @(posedge i_clk);
        calm_phase <= 1'b1;

        wait (pending_queries.size() == 0);
        @(posedge i_clk);
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (mismatch_count == 0 && expected_contacts.size() == 0)
            $display("PASS aabb_overlap_separation");
        else
            $display("FAIL aabb_overlap_separation");
        $finish;
    end

endmodule

// ===== aabb_overlap_separation.f =====
rtl/aabb_pkg.sv
rtl/aabb_sqrt_cell.sv
rtl/aabb_div_cell.sv
rtl/aabb_overlap_separation.sv
verif/aabb_overlap_separation_test.sv
